@@ hw/rtl/dvfs_pkg.sv @@
package dvfs_pkg;

    localparam int MAX_DISTINCT = 32;
    localparam int COUNT_BITS   = 16;
    localparam int VALUE_W      = 32;
    localparam int OCC_W        = 16;
    localparam int RANK_W       = 5;
    localparam int PHASE_W      = $clog2(MAX_DISTINCT + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    localparam logic [1:0] OP_HOLD  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_SORT  = 2'd2;
    localparam logic [1:0] OP_SHIFT = 2'd3;

    typedef struct packed {
        logic                  valid;
        logic [VALUE_W-1:0]    value;
        logic [COUNT_BITS-1:0] count;
    } entry_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [VALUE_W-1:0] sample;
        logic               any_match;
    } cell_ctl_t;

endpackage

@@ hw/rtl/dvfs_cell.sv @@
module dvfs_cell
    import dvfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic      pair_left,
    input  entry_t    prev,
    input  entry_t    next,
    output entry_t    cur,
    output logic      match
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [VALUE_W-1:0]    value_reg;
    logic [VALUE_W-1:0]    value_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  swap_right;
    logic                  swap_left;

    assign cur.valid = valid_reg;
    assign cur.value = value_reg;
    assign cur.count = count_reg;

    assign match      = valid_reg && (value_reg == ctl.sample);
    assign swap_right = valid_reg && next.valid && (count_reg > next.count);
    assign swap_left  = valid_reg && prev.valid && (prev.count > count_reg);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        count_next = count_reg;
        case (ctl.op)
            OP_LOAD:
            begin
                if (match)
                begin
                    if (count_reg != COUNT_TOP)
                    begin
                        count_next = count_reg + COUNT_ONE;
                    end
                end
                else if (!valid_reg && prev.valid && !ctl.any_match)
                begin
                    valid_next = 1'b1;
                    value_next = ctl.sample;
                    count_next = COUNT_ONE;
                end
            end
            OP_SORT:
            begin
                if (pair_left && swap_right)
                begin
                    value_next = next.value;
                    count_next = next.count;
                end
                else if (!pair_left && swap_left)
                begin
                    value_next = prev.value;
                    count_next = prev.count;
                end
            end
            OP_SHIFT:
            begin
                valid_next = next.valid;
                value_next = next.value;
                count_next = next.count;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        count_reg <= count_next;
    end

endmodule

@@ hw/rtl/distinct_value_frequency_sort_core.sv @@
// Counts distinct signed values of a data set and reports them sorted by ascending count, ties
// in order of first appearance. Each item is latched, then compared and updated in parallel
// across the chain of MAX_DISTINCT cells. After the item marked final_item the chain
// runs MAX_DISTINCT odd-even transposition phases, then shifts one entry out per cycle, with
// busy high throughout. Results appear one per cycle on strobe, the first in the cycle after
// emission starts; the receiver cannot stall them and must take each one when strobe is high.
module distinct_value_frequency_sort_core
    import dvfs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [VALUE_W-1:0] sample,
    input  logic                      final_item,
    output logic                      strobe,
    output logic signed [VALUE_W-1:0] distinct_value,
    output logic [OCC_W-1:0]          occurrences,
    output logic [RANK_W-1:0]         rank,
    output logic                      end_of_run,
    output logic                      overflowed
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_SORT   = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(MAX_DISTINCT - 1);

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  phase_next;
    logic [VALUE_W-1:0]  sample_reg;
    logic                final_reg;
    logic                overflow_reg;
    logic                overflow_next;
    logic [RANK_W-1:0]   rank_reg;
    logic [RANK_W-1:0]   rank_next;
    logic                strobe_reg;
    logic [VALUE_W-1:0]  value_out_reg;
    logic [OCC_W-1:0]    occ_out_reg;
    logic [RANK_W-1:0]   rank_out_reg;
    logic                end_out_reg;
    logic                ovf_out_reg;

    cell_ctl_t           ctl;
    entry_t              cells   [MAX_DISTINCT];
    entry_t              prevs   [MAX_DISTINCT];
    entry_t              nexts   [MAX_DISTINCT];
    logic [MAX_DISTINCT-1:0] hits;
    logic                accept;
    logic                last_out;

    assign accept   = start && !busy;
    assign busy     = (state_reg != ST_IDLE);
    assign last_out = !nexts[0].valid;

    always_comb
    begin
        ctl.sample    = sample_reg;
        ctl.any_match = |hits;
        case (state_reg)
            ST_UPDATE: ctl.op = OP_LOAD;
            ST_SORT:   ctl.op = OP_SORT;
            ST_EMIT:   ctl.op = OP_SHIFT;
            default:   ctl.op = OP_HOLD;
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_DISTINCT; gi++)
        begin : g_chain
            logic pair_left;

            if (gi == 0)
            begin : g_head
                assign prevs[gi] = '{valid: 1'b1, value: '0, count: '0};
            end
            else
            begin : g_mid
                assign prevs[gi] = cells[gi-1];
            end

            if (gi == MAX_DISTINCT - 1)
            begin : g_tail
                assign nexts[gi] = '{valid: 1'b0, value: '0, count: '0};
            end
            else
            begin : g_body
                assign nexts[gi] = cells[gi+1];
            end

            assign pair_left = ((gi % 2) != 0) ? phase_reg[0] : !phase_reg[0];

            dvfs_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .pair_left (pair_left),
                .prev      (prevs[gi]),
                .next      (nexts[gi]),
                .cur       (cells[gi]),
                .match     (hits[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        overflow_next = overflow_reg;
        rank_next     = rank_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!(|hits) && cells[MAX_DISTINCT-1].valid)
                begin
                    overflow_next = 1'b1;
                end
                phase_next = '0;
                state_next = final_reg ? ST_SORT : ST_IDLE;
            end
            ST_SORT:
            begin
                phase_next = phase_reg + PHASE_W'(1);
                if (phase_reg == PHASE_LAST)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                rank_next = rank_reg + RANK_W'(1);
                if (last_out)
                begin
                    state_next    = ST_IDLE;
                    overflow_next = 1'b0;
                    rank_next     = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= '0;
            overflow_reg <= 1'b0;
            rank_reg     <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            overflow_reg <= overflow_next;
            rank_reg     <= rank_next;
            strobe_reg   <= (state_reg == ST_EMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= $unsigned(sample);
            final_reg  <= final_item;
        end
        if (state_reg == ST_EMIT)
        begin
            value_out_reg <= cells[0].value;
            occ_out_reg   <= OCC_W'(cells[0].count);
            rank_out_reg  <= rank_reg;
            end_out_reg   <= last_out;
            ovf_out_reg   <= overflow_reg;
        end
    end

    assign strobe         = strobe_reg;
    assign distinct_value = $signed(value_out_reg);
    assign occurrences    = occ_out_reg;
    assign rank           = rank_out_reg;
    assign end_of_run     = end_out_reg;
    assign overflowed     = ovf_out_reg;

endmodule

@@ hw/rtl/dvfs_checker.sv @@
module dvfs_checker
    import dvfs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              strobe,
    input logic [RANK_W-1:0] rank,
    input logic              end_of_run,
    input logic              overflowed
);

    // a run is emitted back to back
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !end_of_run |=> strobe)
        else $error("gap inside an output run");

    a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !end_of_run |=> rank == RANK_W'($past(rank) + RANK_W'(1)))
        else $error("rank did not advance by one");

    a_run_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && end_of_run |=> !strobe)
        else $error("transfer right after end of run");

    a_ovf_stable: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !end_of_run |=> overflowed == $past(overflowed))
        else $error("overflow flag changed within a run");

    a_busy_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("transfer not followed by busy");

endmodule

bind distinct_value_frequency_sort_core dvfs_checker u_dvfs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .strobe         (strobe),
    .rank           (rank),
    .end_of_run     (end_of_run),
    .overflowed     (overflowed)
);

@@ test/distinct_value_frequency_sort_core_test.sv @@
module distinct_value_frequency_sort_core_test;
    import dvfs_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 2 * MAX_DISTINCT + 8;
    localparam int RANDOM_ITEMS = 300;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [OCC_W-1:0]          occ;
        logic [RANK_W-1:0]         rank;
        logic                      last;
        logic                      ovf;
    } freq_pair_t;

    typedef enum {ROW_SINGLE, ROW_REPEAT, ROW_RAMP} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic signed [VALUE_W-1:0] base;
        int                        reps;
        logic                      last;
        bit                        typed;
        freq_pair_t                want;
    } stim_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic signed [VALUE_W-1:0] sample = '0;
    logic                      final_item = 1'b0;
    logic                      busy;
    logic                      strobe;
    logic signed [VALUE_W-1:0] distinct_value;
    logic [OCC_W-1:0]          occurrences;
    logic [RANK_W-1:0]         rank;
    logic                      end_of_run;
    logic                      overflowed;

    freq_pair_t                pending_pairs[$];
    int                        mismatches = 0;
    int                        idle_count = 0;

    // predictor state
    logic signed [VALUE_W-1:0] seen_value [MAX_DISTINCT];
    logic [COUNT_BITS-1:0]     seen_count [MAX_DISTINCT];
    int                        seen_used = 0;
    bit                        seen_overflow = 0;

    // extremes, tie order, repeated value, table overflow, full table without overflow
    stim_row_t directed_rows [18] = '{
        '{ROW_SINGLE, 32'sh80000000, 1, 1'b1, 1'b1, '{32'sh80000000, 16'd1, 5'd0, 1'b1, 1'b0}},
        '{ROW_SINGLE, 32'sh7fffffff, 1, 1'b1, 1'b1, '{32'sh7fffffff, 16'd1, 5'd0, 1'b1, 1'b0}},
        '{ROW_SINGLE, 32'sh00000000, 1, 1'b1, 1'b1, '{32'sh00000000, 16'd1, 5'd0, 1'b1, 1'b0}},
        '{ROW_SINGLE, 32'shffffffff, 1, 1'b1, 1'b1, '{32'shffffffff, 16'd1, 5'd0, 1'b1, 1'b0}},
        '{ROW_SINGLE, 32'sd5, 1, 1'b0, 1'b0, '0},
        '{ROW_SINGLE, 32'sd7, 1, 1'b0, 1'b0, '0},
        '{ROW_SINGLE, 32'sd5, 1, 1'b0, 1'b0, '0},
        '{ROW_SINGLE, 32'sd7, 1, 1'b0, 1'b0, '0},
        '{ROW_SINGLE, 32'sd3, 1, 1'b0, 1'b0, '0},
        '{ROW_SINGLE, 32'sd9, 1, 1'b1, 1'b0, '0},
        '{ROW_REPEAT, 32'sd1234, 20, 1'b0, 1'b0, '0},
        '{ROW_SINGLE, -32'sd8, 1, 1'b0, 1'b0, '0},
        '{ROW_SINGLE, 32'sd1234, 1, 1'b1, 1'b0, '0},
        '{ROW_RAMP, 32'sd100, 40, 1'b0, 1'b0, '0},
        '{ROW_SINGLE, 32'sd100, 1, 1'b0, 1'b0, '0},
        '{ROW_SINGLE, 32'sd200, 1, 1'b1, 1'b0, '0},
        '{ROW_SINGLE, 32'sd0, 1, 1'b1, 1'b1, '{32'sd0, 16'd1, 5'd0, 1'b1, 1'b0}},
        '{ROW_RAMP, -32'sd16, 32, 1'b1, 1'b0, '0}
    };

    distinct_value_frequency_sort_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .sample         (sample),
        .final_item     (final_item),
        .strobe         (strobe),
        .distinct_value (distinct_value),
        .occurrences    (occurrences),
        .rank           (rank),
        .end_of_run     (end_of_run),
        .overflowed     (overflowed)
    );

    always #5 clk = ~clk;

    function automatic void tally_sample(logic signed [VALUE_W-1:0] s, logic last, bit emit);
        logic signed [VALUE_W-1:0] sorted_value [MAX_DISTINCT];
        logic [COUNT_BITS-1:0]     sorted_count [MAX_DISTINCT];
        logic signed [VALUE_W-1:0] v;
        logic [COUNT_BITS-1:0]     c;
        freq_pair_t                pair;
        bit                        hit;
        int                        i;
        int                        j;
        hit = 0;
        for (i = 0; i < seen_used; i++)
        begin
            if (!hit && seen_value[i] == s)
            begin
                hit = 1;
                if (seen_count[i] != COUNT_TOP)
                    seen_count[i] = seen_count[i] + COUNT_ONE;
            end
        end
        if (!hit)
        begin
            if (seen_used < MAX_DISTINCT)
            begin
                seen_value[seen_used] = s;
                seen_count[seen_used] = COUNT_ONE;
                seen_used++;
            end
            else
                seen_overflow = 1;
        end
        if (!last)
            return;
        for (i = 0; i < seen_used; i++)
        begin
            sorted_value[i] = seen_value[i];
            sorted_count[i] = seen_count[i];
        end
        // stable insertion sort, ascending count
        for (i = 1; i < seen_used; i++)
        begin
            v = sorted_value[i];
            c = sorted_count[i];
            j = i;
            while (j > 0 && sorted_count[j-1] > c)
            begin
                sorted_value[j] = sorted_value[j-1];
                sorted_count[j] = sorted_count[j-1];
                j--;
            end
            sorted_value[j] = v;
            sorted_count[j] = c;
        end
        for (i = 0; i < seen_used; i++)
        begin
            pair.value = sorted_value[i];
            pair.occ   = sorted_count[i][OCC_W-1:0];
            pair.rank  = RANK_W'(i);
            pair.last  = (i == seen_used - 1);
            pair.ovf   = seen_overflow;
            if (emit)
                pending_pairs.push_back(pair);
        end
        seen_used = 0;
        seen_overflow = 0;
    endfunction

    function automatic void flag_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic pause(int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_pairs.size() != 0);
        @(posedge clk);
    endtask

    // start stays high on return so a back-to-back transfer needs no toggle
    task automatic transfer_sample(logic signed [VALUE_W-1:0] s, logic last, bit typed,
                                   freq_pair_t want);
        start      <= 1'b1;
        sample     <= s;
        final_item <= last;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (typed)
            pending_pairs.push_back(want);
        tally_sample(s, last, !typed);
    endtask

    always @(posedge clk)
    begin : check_result
        freq_pair_t want;
        if (rst_n && strobe)
        begin
            if (pending_pairs.size() == 0)
            begin
                $display("%0t: unexpected result, value %0d count %0d rank %0d", $time,
                         distinct_value, occurrences, rank);
                mismatches++;
            end
            else
            begin
                want = pending_pairs.pop_front();
                flag_field("distinct_value", want.value, distinct_value);
                flag_field("occurrences", want.occ, occurrences);
                flag_field("rank", want.rank, rank);
                flag_field("end_of_run", want.last, end_of_run);
                flag_field("overflowed", want.ovf, overflowed);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            idle_count <= 0;
        else
        begin
            idle_count <= idle_count + 1;
            if (idle_count == STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [VALUE_W-1:0] s;
        logic signed [VALUE_W-1:0] pool [8];
        int                        r;
        int                        k;
        int                        pool_n;
        int                        set_len;
        int                        style;
        int                        sets_done;
        int                        items_sent;
        bit                        burst;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < $size(directed_rows); r++)
        begin
            for (k = 0; k < directed_rows[r].reps; k++)
            begin
                s = directed_rows[r].base;
                if (directed_rows[r].kind == ROW_RAMP)
                    s = s + k;
                if (directed_rows[r].reps <= 64)
                    pause($urandom_range(0, 6));
                transfer_sample(s, directed_rows[r].last && k == directed_rows[r].reps - 1,
                                directed_rows[r].typed, directed_rows[r].want);
            end
        end
        wait_drained();

        items_sent = 0;
        sets_done = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            style = $urandom_range(0, 9);
            burst = ($urandom_range(0, 3) == 0);
            pool_n = $urandom_range(1, 8);
            for (k = 0; k < 8; k++)
                pool[k] = $urandom;
            if (style == 8)
                set_len = $urandom_range(33, 45);
            else if (style == 9)
                set_len = $urandom_range(1, 3);
            else if (style >= 6)
                set_len = $urandom_range(1, 12);
            else
                set_len = $urandom_range(1, 16);
            for (k = 0; k < set_len; k++)
            begin
                case (style)
                    6, 7: s = $urandom;
                    8: s = ($urandom_range(0, 7) == 0) ? pool[0] : $urandom;
                    9:
                    begin
                        case ($urandom_range(0, 4))
                            0: s = 32'sh80000000;
                            1: s = 32'sh7fffffff;
                            2: s = 32'sh00000000;
                            3: s = 32'shffffffff;
                            default: s = pool[0];
                        endcase
                    end
                    default: s = pool[$urandom_range(0, pool_n - 1)];
                endcase
                if (!burst)
                    pause($urandom_range(0, 6));
                transfer_sample(s, k == set_len - 1, 1'b0, '0);
                items_sent++;
            end
            sets_done++;
            if (sets_done % 5 == 0)
                wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_pairs.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
